>>> sv/csm_pkg.sv
// Shared types and constants for the contiguous sequence match block.
// Used by csm_window_cmp and contiguous_sequence_match; depends on nothing.

package csm_pkg;

   localparam int PatternMax = 16;
   localparam int WordWidth  = 32;

   typedef logic [WordWidth-1:0]  word_type;
   typedef logic [PatternMax-1:0] mask_type;
   typedef word_type              words_type [PatternMax];

   // request kinds carried on tuser
   localparam logic ModePattern = 1'b0;
   localparam logic ModeText    = 1'b1;

endpackage

>>> sv/csm_window_cmp.sv
// Parallel compare of the text window against the right-aligned pattern.
// Depends on csm_pkg for word and mask types.

module csm_window_cmp (
   input  csm_pkg::words_type pattern,   // right-aligned, newest word at the top
   input  csm_pkg::words_type window,    // text window after this word shifts in
   input  csm_pkg::mask_type  pattern_mask,
   input  csm_pkg::mask_type  text_mask,
   output logic               hit
);
   import csm_pkg::*;

   mask_type slot_ok;

   // a slot outside the pattern always passes; inside it needs a text word and equality
   always_comb begin
      for (int j = 0; j < PatternMax; j++) begin
         slot_ok[j] = !pattern_mask[j] || (text_mask[j] && (pattern[j] == window[j]));
      end
   end

   assign hit = &slot_ok;

endmodule

>>> sv/contiguous_sequence_match.sv
// Contiguous sequence match: one request per cycle sustained; the whole window compare sits
// between the input register and the result register.
// A text request marked last passes the input register, then loads the result register.
// Throughput: one request per cycle while the result side keeps up.
// Reset (synchronous, active high): empty pattern, closed; text state cleared; no result held.
// Depends on csm_pkg and csm_window_cmp.

module contiguous_sequence_match (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tuser,   // [0] mode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] found, [1] overflow, [7:2] zero
);
   import csm_pkg::*;

   // input register
   logic      in_valid_ff, in_valid_in;
   logic      mode_ff;
   word_type  value_ff;
   logic      last_ff;

   // block state
   words_type pstore_ff, pstore_in;
   mask_type  pmask_ff, pmask_in;
   logic      closed_ff, closed_in;
   logic      over_ff, over_in;
   words_type window_ff, window_in, window_next;
   mask_type  tmask_ff, tmask_in, tmask_next;
   logic      match_ff, match_in;

   // result register
   logic      out_valid_ff, out_valid_in;
   logic      found_ff, found_in;
   logic      out_over_ff, out_over_in;

   logic      gives_result;
   logic      advance;
   logic      hit;
   mask_type  pmask_base;
   logic      load_out;

   assign gives_result = (mode_ff == ModeText) && last_ff;
   assign advance      = in_valid_ff && (!gives_result || !out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;

   // window after this word shifts in, newest at the top
   always_comb begin
      for (int j = 0; j < PatternMax - 1; j++) begin
         window_next[j] = window_ff[j+1];
      end
      window_next[PatternMax-1] = value_ff;
   end
   assign tmask_next = {1'b1, tmask_ff[PatternMax-1:1]};

   csm_window_cmp u_cmp (
      .pattern      (pstore_ff),
      .window       (window_next),
      .pattern_mask (pmask_ff),
      .text_mask    (tmask_next),
      .hit          (hit)
   );

   assign pmask_base = closed_ff ? '0 : pmask_ff;

   always_comb begin
      pstore_in   = pstore_ff;
      pmask_in    = pmask_ff;
      closed_in   = closed_ff;
      over_in     = over_ff;
      window_in   = window_ff;
      tmask_in    = tmask_ff;
      match_in    = match_ff;
      load_out    = 1'b0;
      found_in    = found_ff;
      out_over_in = out_over_ff;
      if (advance) begin
         if (mode_ff == ModePattern) begin
            // a closed pattern restarts and abandons any text in progress
            if (closed_ff) begin
               over_in  = 1'b0;
               tmask_in = '0;
               match_in = 1'b0;
            end
            pmask_in = pmask_base;
            if (!pmask_base[0]) begin
               pmask_in = {1'b1, pmask_base[PatternMax-1:1]};
               for (int j = 0; j < PatternMax - 1; j++) begin
                  pstore_in[j] = pstore_ff[j+1];
               end
               pstore_in[PatternMax-1] = value_ff;
            end else begin
               over_in = 1'b1;
            end
            closed_in = last_ff;
         end else begin
            closed_in = 1'b1;
            window_in = window_next;
            tmask_in  = tmask_next;
            match_in  = match_ff || hit;
            if (last_ff) begin
               load_out    = 1'b1;
               found_in    = match_ff || hit;
               out_over_in = over_ff;
               tmask_in    = '0;
               match_in    = 1'b0;
            end
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pmask_ff     <= '0;
         closed_ff    <= 1'b1;
         over_ff      <= 1'b0;
         tmask_ff     <= '0;
         match_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pmask_ff     <= pmask_in;
         closed_ff    <= closed_in;
         over_ff      <= over_in;
         tmask_ff     <= tmask_in;
         match_ff     <= match_in;
      end
   end

   // payload: no reset, masks gate stale words
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         mode_ff  <= req_tuser;
         value_ff <= req_tdata;
         last_ff  <= req_tlast;
      end
      pstore_ff   <= pstore_in;
      window_ff   <= window_in;
      found_ff    <= found_in;
      out_over_ff <= out_over_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_over_ff, found_ff};

   // a text request marked last always lands in the result register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (advance && gives_result) |=> out_valid_ff)
      else $error("text end did not produce a result");

   // the pattern occupies a contiguous run of slots from the top
   a_pmask_aligned: assert property (@(posedge clock) disable iff (reset)
      (((pmask_ff << 1) & ~pmask_ff) == '0))
      else $error("pattern mask not top-aligned");

   // overflow is only possible once every slot is filled
   a_over_full: assert property (@(posedge clock) disable iff (reset)
      over_ff |-> pmask_ff[0])
      else $error("overflow flagged with room left");

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !load_out)
      else $error("waiting result overwritten");

endmodule

>>> tb/tb_contiguous_sequence_match.sv
// Self-checking testbench for contiguous_sequence_match: directed table, then random searches.
// Predicts each verdict from its own copy of the pattern and text window state.
// Depends on csm_pkg and the contiguous_sequence_match RTL.
`timescale 1ns / 1ps

module tb_contiguous_sequence_match;
   import csm_pkg::*;

   localparam int StuckLimit  = 3000;
   localparam int DrainCycles = 8;
   localparam int PhaseItems  = 255;
   localparam int NumPhases   = 4;
   localparam int SendIdlePct [NumPhases] = '{0, 74, 0, 21};
   localparam int RecvStallPct[NumPhases] = '{0, 0, 74, 21};

   // verdict byte as it travels on rsp_tdata: [0] found, [1] overflow
   localparam logic [7:0] Miss      = 8'h00;
   localparam logic [7:0] Hit       = 8'h01;
   localparam logic [7:0] TruncMiss = 8'h02;

   typedef struct packed {
      logic       mode;
      word_type   value;
      logic       last;
      logic [4:0] reps;    // value counts up across repeats; last applies to the final one
      logic       typed;
      logic [7:0] verdict;
   } stim_row_type;

   localparam int NumRows = 22;
   localparam stim_row_type DirRows [NumRows] = '{
      '{ModeText,    32'h0000_0000, 1'b1, 5'd1,  1'b1, Hit},        // empty pattern after reset
      '{ModePattern, 32'h8000_0000, 1'b0, 5'd1,  1'b0, Miss},
      '{ModePattern, 32'h7FFF_FFFF, 1'b1, 5'd1,  1'b0, Miss},
      '{ModeText,    32'hFFFF_FFFF, 1'b0, 5'd1,  1'b0, Miss},
      '{ModeText,    32'h8000_0000, 1'b0, 5'd1,  1'b0, Miss},
      '{ModeText,    32'h7FFF_FFFF, 1'b1, 5'd1,  1'b1, Hit},
      '{ModeText,    32'h7FFF_FFFF, 1'b1, 5'd1,  1'b1, Miss},       // text shorter than pattern
      '{ModePattern, 32'h0000_0005, 1'b0, 5'd1,  1'b0, Miss},
      '{ModePattern, 32'h0000_0006, 1'b0, 5'd1,  1'b0, Miss},       // pattern left open
      '{ModeText,    32'h0000_0005, 1'b0, 5'd1,  1'b0, Miss},
      '{ModeText,    32'h0000_0006, 1'b1, 5'd1,  1'b1, Hit},
      '{ModePattern, 32'h0000_0001, 1'b1, 5'd1,  1'b0, Miss},
      '{ModeText,    32'h0000_0001, 1'b0, 5'd1,  1'b0, Miss},
      '{ModePattern, 32'h0000_0002, 1'b1, 5'd1,  1'b0, Miss},       // abandons the text
      '{ModeText,    32'h0000_0003, 1'b1, 5'd1,  1'b1, Miss},
      '{ModePattern, 32'h0000_0064, 1'b1, 5'd17, 1'b0, Miss},       // one word too many
      '{ModeText,    32'h0000_0064, 1'b1, 5'd1,  1'b1, TruncMiss},
      '{ModePattern, 32'h0000_0064, 1'b1, 5'd17, 1'b0, Miss},
      '{ModeText,    32'h0000_0064, 1'b1, 5'd16, 1'b0, Miss},
      '{ModePattern, 32'hFFFF_FFFF, 1'b1, 5'd1,  1'b0, Miss},
      '{ModeText,    32'hFFFF_FFFF, 1'b0, 5'd1,  1'b0, Miss},
      '{ModeText,    32'h0000_0000, 1'b1, 5'd1,  1'b0, Miss}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic        req_tuser = 1'b0; // [0] mode
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] found, [1] overflow, [7:2] zero

   // predictor state
   word_type    pat_words [PatternMax];
   int          pat_len;
   bit          pat_closed;
   bit          pat_truncated;
   word_type    win_words [PatternMax];
   int          text_count;
   bit          hit_sticky;

   logic [7:0]  verdict_q [$];
   logic [7:0]  want_verdict;
   int          mismatch_count = 0;
   int          stuck_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   word_type    session_alphabet [3];

   contiguous_sequence_match i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_text();
      for (int i = 0; i < PatternMax; i++) win_words[i] = '0;
      text_count = 0;
      hit_sticky = 1'b0;
   endfunction

   task automatic search_step(input logic mode, input word_type value, input logic last,
                              output bit has_verdict, output logic [7:0] verdict);
      bit window_hit;
      has_verdict = 1'b0;
      verdict = Miss;
      if (mode == ModePattern) begin
         if (pat_closed) begin
            pat_len = 0;
            pat_truncated = 1'b0;
            pat_closed = 1'b0;
            clear_text();
         end
         if (pat_len < PatternMax) begin
            pat_words[pat_len] = value;
            pat_len++;
         end else begin
            pat_truncated = 1'b1;
         end
         if (last) pat_closed = 1'b1;
      end else begin
         pat_closed = 1'b1;
         for (int i = 0; i < PatternMax - 1; i++) win_words[i] = win_words[i+1];
         win_words[PatternMax-1] = value;
         if (text_count < PatternMax) text_count++;
         // compare the newest pat_len window words; an empty pattern always hits
         window_hit = 1'b1;
         if (pat_len != 0) begin
            if (text_count < pat_len) begin
               window_hit = 1'b0;
            end else begin
               for (int i = 0; i < pat_len; i++)
                  if (pat_words[i] != win_words[PatternMax-pat_len+i]) window_hit = 1'b0;
            end
         end
         if (window_hit) hit_sticky = 1'b1;
         if (last) begin
            has_verdict = 1'b1;
            verdict = {6'b0, pat_truncated, hit_sticky};
            clear_text();
         end
      end
   endtask

   // drive one request, wait for it to be taken, then predict its verdict
   task automatic send_request(input logic mode, input word_type value, input logic last,
                               input logic typed, input logic [7:0] typed_verdict);
      bit         has_verdict;
      logic [7:0] verdict;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= mode;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      search_step(mode, value, last, has_verdict, verdict);
      if (has_verdict) verdict_q.push_back(typed ? typed_verdict : verdict);
   endtask

   function automatic word_type pick_word(bit narrow);
      return narrow ? session_alphabet[$urandom_range(2, 0)] : word_type'($urandom());
   endfunction

   // one pattern followed by up to three texts, some of which carry it somewhere, or else a noise mix
   task automatic run_search_session(inout int sent);
      word_type planted [PatternMax+4];
      word_type w;
      int       pick, plen, kept, tlen, pos, flip_at;
      bit       narrow, open_end, plant, abandon;
      narrow = 1'($urandom_range(1, 0));
      for (int a = 0; a < 3; a++) session_alphabet[a] = $urandom();
      if ($urandom_range(99, 0) < 8) begin
         // noise: loose mix of pattern and text requests
         repeat ($urandom_range(10, 1)) begin
            send_request(1'($urandom_range(1, 0)), $urandom(), $urandom_range(99, 0) < 30,
                         1'b0, Miss);
            sent++;
         end
         return;
      end
      pick = $urandom_range(99, 0);
      if (pick < 55)      plen = $urandom_range(4, 1);
      else if (pick < 80) plen = $urandom_range(PatternMax - 1, 5);
      else if (pick < 90) plen = PatternMax;
      else                plen = $urandom_range(PatternMax + 4, PatternMax + 1);
      kept = (plen > PatternMax) ? PatternMax : plen;
      open_end = $urandom_range(99, 0) < 10;
      for (int i = 0; i < plen; i++) begin
         planted[i] = pick_word(narrow);
         send_request(ModePattern, planted[i], !open_end && i == plen - 1, 1'b0, Miss);
         sent++;
      end
      repeat ($urandom_range(3, 1)) begin
         tlen = $urandom_range(kept + 6, 1);
         plant = ($urandom_range(99, 0) < 60) && tlen >= kept;
         pos = plant ? $urandom_range(tlen - kept, 0) : 0;
         flip_at = (plant && $urandom_range(99, 0) < 25) ? pos + $urandom_range(kept - 1, 0)
                                                        : -1;
         abandon = $urandom_range(99, 0) < 4;
         for (int j = 0; j < tlen; j++) begin
            w = (plant && j >= pos && j < pos + kept) ? planted[j-pos] : pick_word(narrow);
            if (j == flip_at) w = w ^ (word_type'(1) << $urandom_range(31, 0));
            if (abandon && j == tlen / 2) begin
               // stop mid-text; the next pattern request drops it
               send_request(ModeText, w, 1'b0, 1'b0, Miss);
               sent++;
               return;
            end
            send_request(ModeText, w, j == tlen - 1, 1'b0, Miss);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected verdict: expected none, actual found=%0b overflow=%0b",
                     $time, rsp_tdata[0], rsp_tdata[1]);
            mismatch_count++;
         end else begin
            want_verdict = verdict_q.pop_front();
            if (rsp_tdata !== want_verdict) begin
               $display("%0t: verdict mismatch: expected found=%0b overflow=%0b pad=%h, %s",
                        $time, want_verdict[0], want_verdict[1], want_verdict[7:2],
                        $sformatf("actual found=%0b overflow=%0b pad=%h",
                                  rsp_tdata[0], rsp_tdata[1], rsp_tdata[7:2]));
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == StuckLimit) begin
         $display("contiguous_sequence_match verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int sent;
      pat_len = 0;
      pat_closed = 1'b1;
      pat_truncated = 1'b0;
      for (int i = 0; i < PatternMax; i++) pat_words[i] = '0;
      clear_text();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NumRows; r++) begin
         for (int k = 0; k < int'(DirRows[r].reps); k++) begin
            send_request(DirRows[r].mode, DirRows[r].value + word_type'(k),
                         (k == int'(DirRows[r].reps) - 1) ? DirRows[r].last : 1'b0,
                         DirRows[r].typed, DirRows[r].verdict);
         end
      end

      for (int p = 0; p < NumPhases; p++) begin
         send_idle_pct = SendIdlePct[p];
         recv_stall_pct = RecvStallPct[p];
         sent = 0;
         while (sent < PhaseItems) run_search_session(sent);
         // hold off until every outstanding verdict has been taken
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (verdict_q.size() != 0) @(posedge clock);
      end

      recv_stall_pct = 0;
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("contiguous_sequence_match verification clean");
      end else begin
         $display("contiguous_sequence_match verification failed");
      end
      $finish;
   end

endmodule

>>> contiguous_sequence_match.f
sv/csm_pkg.sv
sv/csm_window_cmp.sv
sv/contiguous_sequence_match.sv
tb/tb_contiguous_sequence_match.sv
